>>> rtl/box_nonmax_suppression_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for box_nonmax_suppression_top
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef BOX_NONMAX_SUPPRESSION_TOP_DEFINES_SVH
`define BOX_NONMAX_SUPPRESSION_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define BNMS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define BNMS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/bnms_pkg.sv
// ----------------------------------------------------------------------------
// bnms_pkg
// Types and constants for the box suppression block.
// ----------------------------------------------------------------------------
package bnms_pkg;
  localparam int MaxBoxesDefault = 64;
  localparam int CoordW = 16;
  localparam int ScoreW = 16;
  localparam int IndexW = 6;
  localparam logic [15:0] ThreshReset = 16'd26214;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_CUR,
    ST_SORT_RANK,
    ST_SORT_SCORE,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_SUP_A,
    ST_SUP_AIDX,
    ST_SUP_ACHK,
    ST_SUP_AAREA,
    ST_SUP_B,
    ST_SUP_BIDX,
    ST_SUP_GEOM,
    ST_SUP_MUL_I,
    ST_SUP_MUL_B,
    ST_SUP_MUL_T,
    ST_SUP_DEC,
    ST_EMIT_INIT,
    ST_EMIT_RD,
    ST_EMIT_CHK,
    ST_EMIT
  } state_t;
endpackage

>>> rtl/bnms_ram.sv
// ----------------------------------------------------------------------------
// bnms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bnms_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/box_nonmax_suppression_top.sv
// ----------------------------------------------------------------------------
// box_nonmax_suppression_top
// Greedy IoU non-maximum suppression over one set of detection boxes.
// ----------------------------------------------------------------------------
// Boxes load one per cycle (ready high in the load phase) until last_box. The
// set is then ranked by descending confidence with ties in input order, using
// an insertion sort through the rank RAM. Suppression walks the ranking with
// one shared 34x16 multiplier: the area of each kept box is formed once, later
// boxes that are already suppressed are skipped, and each other later box gets
// the IoU test. Kept indices then leave in ascending order, each held until
// out_ready, the last one flagged with last_kept. Boxes past MAX_BOXES are
// dropped; a dropped box with last_box still closes the set. Input is not taken
// until the last result is delivered; ready rises the cycle after. Suppression
// flags sit in a RAM and are cleared entry by entry as the boxes load.
module box_nonmax_suppression_top #(
  parameter int MAX_BOXES = bnms_pkg::MaxBoxesDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [15:0]                 cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bnms_pkg::CoordW-1:0] x_min,
  input  logic [bnms_pkg::CoordW-1:0] y_min,
  input  logic [bnms_pkg::CoordW-1:0] x_max,
  input  logic [bnms_pkg::CoordW-1:0] y_max,
  input  logic [bnms_pkg::ScoreW-1:0] confidence,
  input  logic                        last_box,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bnms_pkg::IndexW-1:0] kept_index,
  output logic                        last_kept
);
  import bnms_pkg::*;
  `include "box_nonmax_suppression_top_defines.svh"

  localparam int AW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);

  state_t state, state_next;

  logic [15:0]   thresh;
  logic [CW-1:0] count;       // boxes in the set
  logic [CW-1:0] i_cnt;       // outer index: box to insert / rank / emit position
  logic [CW-1:0] k_cnt;       // insertion slot / inner rank index
  logic [CW-1:0] k_dec;
  logic [CW-1:0] supp_cnt;    // boxes suppressed in this set
  logic [CW-1:0] kept_total, emit_seen;
  logic          room;

  // RAMs: corners, scores and flags by input position, rank by rank position
  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [63:0]   crn_rdata;
  logic [15:0]   scr_rdata;
  logic          rk_we;
  logic [AW-1:0] rk_waddr, rk_raddr;
  logic [AW-1:0] rk_wdata, rk_rdata;
  logic          sp_we, sp_wdata, sp_rdata;
  logic [AW-1:0] sp_waddr, sp_raddr;

  logic [15:0]   cur_score;
  logic [AW-1:0] prev_rank;
  logic [AW-1:0] b_idx;
  logic [63:0]   a_box;

  logic load_take;
  assign load_take = in_valid && in_ready;
  assign room      = count < CW'(MAX_BOXES);
  assign k_dec     = k_cnt - CW'(1);

  bnms_ram #(.Width(64), .Depth(MAX_BOXES)) u_crn (
    .clk, .we(st_we), .waddr(st_waddr),
    .wdata({y_max, x_max, y_min, x_min}), .raddr(st_raddr), .rdata(crn_rdata)
  );
  bnms_ram #(.Width(16), .Depth(MAX_BOXES)) u_scr (
    .clk, .we(st_we), .waddr(st_waddr),
    .wdata(confidence), .raddr(st_raddr), .rdata(scr_rdata)
  );
  bnms_ram #(.Width(AW), .Depth(MAX_BOXES)) u_rank (
    .clk, .we(rk_we), .waddr(rk_waddr),
    .wdata(rk_wdata), .raddr(rk_raddr), .rdata(rk_rdata)
  );
  bnms_ram #(.Width(1), .Depth(MAX_BOXES)) u_supp (
    .clk, .we(sp_we), .waddr(sp_waddr),
    .wdata(sp_wdata), .raddr(sp_raddr), .rdata(sp_rdata)
  );

  assign st_we    = load_take && room;
  assign st_waddr = count[AW-1:0];

  // ---------------- geometry datapath ----------------
  logic [15:0] lx, ly, hx, hy;
  logic [15:0] iw, ih, bw, bh;
  logic [15:0] iw_r, ih_r, aw_r, ah_r, bw_r, bh_r;
  logic [31:0] inter_r, area_a_r, area_b_r;
  logic [33:0] union_sum;
  logic [49:0] rhs_r;
  logic [33:0] mul_x;
  logic [15:0] mul_y;
  logic [49:0] mul_p;
  logic        pair_hit;

  function automatic logic [15:0] span16(input logic [15:0] lo, input logic [15:0] hi);
    span16 = (hi > lo) ? hi - lo : 16'd0;
  endfunction

  always_comb begin
    lx = (a_box[15:0]  > crn_rdata[15:0])  ? a_box[15:0]  : crn_rdata[15:0];
    ly = (a_box[31:16] > crn_rdata[31:16]) ? a_box[31:16] : crn_rdata[31:16];
    hx = (a_box[47:32] < crn_rdata[47:32]) ? a_box[47:32] : crn_rdata[47:32];
    hy = (a_box[63:48] < crn_rdata[63:48]) ? a_box[63:48] : crn_rdata[63:48];
    iw = span16(lx, hx);
    ih = span16(ly, hy);
    bw = span16(crn_rdata[15:0], crn_rdata[47:32]);
    bh = span16(crn_rdata[31:16], crn_rdata[63:48]);
  end

  // one multiplier shared by the area, overlap and threshold products
  assign union_sum = 34'(area_a_r) + 34'(area_b_r) - 34'(inter_r);

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (state)
      ST_SUP_AAREA: begin
        mul_x = 34'(aw_r);
        mul_y = ah_r;
      end
      ST_SUP_MUL_I: begin
        mul_x = 34'(iw_r);
        mul_y = ih_r;
      end
      ST_SUP_MUL_B: begin
        mul_x = 34'(bw_r);
        mul_y = bh_r;
      end
      ST_SUP_MUL_T: begin
        mul_x = union_sum;
        mul_y = thresh;
      end
      default: ;
    endcase
  end
  assign mul_p = 50'(mul_x) * 50'(mul_y);

  // inter * 65536 > thresh * union; no overlap never suppresses
  assign pair_hit = (inter_r != 32'd0) && ({2'b00, inter_r, 16'd0} > rhs_r);

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:       if (load_take && last_box) state_next = ST_SORT_RD;
      ST_SORT_RD:    state_next = (i_cnt == count) ? ST_SUP_A : ST_SORT_CUR;
      ST_SORT_CUR:   state_next = (k_cnt == '0) ? ST_SORT_PUT : ST_SORT_RANK;
      ST_SORT_RANK:  state_next = ST_SORT_SCORE;
      ST_SORT_SCORE: state_next = ST_SORT_CMP;
      ST_SORT_CMP: begin
        // keep shifting while rank[k-1] scores lower and a slot is left above
        if (scr_rdata < cur_score && k_cnt != CW'(1)) state_next = ST_SORT_RANK;
        else state_next = ST_SORT_PUT;
      end
      ST_SORT_PUT:   state_next = ST_SORT_RD;
      ST_SUP_A:      state_next = (i_cnt == count) ? ST_EMIT_INIT : ST_SUP_AIDX;
      ST_SUP_AIDX:   state_next = ST_SUP_ACHK;
      ST_SUP_ACHK:   state_next = sp_rdata ? ST_SUP_A : ST_SUP_AAREA;
      ST_SUP_AAREA:  state_next = ST_SUP_B;
      ST_SUP_B:      state_next = (k_cnt == count) ? ST_SUP_A : ST_SUP_BIDX;
      ST_SUP_BIDX:   state_next = ST_SUP_GEOM;
      ST_SUP_GEOM:   state_next = sp_rdata ? ST_SUP_B : ST_SUP_MUL_I;
      ST_SUP_MUL_I:  state_next = ST_SUP_MUL_B;
      ST_SUP_MUL_B:  state_next = ST_SUP_MUL_T;
      ST_SUP_MUL_T:  state_next = ST_SUP_DEC;
      ST_SUP_DEC:    state_next = ST_SUP_B;
      ST_EMIT_INIT:  state_next = ST_EMIT_RD;
      ST_EMIT_RD:    state_next = (i_cnt == count) ? ST_LOAD : ST_EMIT_CHK;
      ST_EMIT_CHK:   state_next = sp_rdata ? ST_EMIT_RD : ST_EMIT;
      ST_EMIT: begin
        if (out_ready) state_next = last_kept ? ST_LOAD : ST_EMIT_RD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // read addresses, write enables and input ready
  always_comb begin
    in_ready = 1'b0;
    st_raddr = '0;
    rk_raddr = '0;
    sp_raddr = '0;
    rk_we    = 1'b0;
    rk_waddr = k_cnt[AW-1:0];
    rk_wdata = prev_rank;
    sp_we    = 1'b0;
    sp_waddr = b_idx;
    sp_wdata = 1'b1;
    unique case (state)
      ST_LOAD: begin
        // clear the flag of each box as it is stored
        in_ready = 1'b1;
        sp_we    = load_take && room;
        sp_waddr = count[AW-1:0];
        sp_wdata = 1'b0;
      end
      ST_SORT_RD:    st_raddr = i_cnt[AW-1:0];
      ST_SORT_RANK:  rk_raddr = k_dec[AW-1:0];
      ST_SORT_SCORE: st_raddr = rk_rdata;
      ST_SORT_CMP:   rk_we = (scr_rdata < cur_score);
      ST_SORT_PUT: begin
        rk_we    = 1'b1;
        rk_wdata = i_cnt[AW-1:0];
      end
      ST_SUP_A:      rk_raddr = i_cnt[AW-1:0];
      ST_SUP_AIDX: begin
        st_raddr = rk_rdata;
        sp_raddr = rk_rdata;
      end
      ST_SUP_B:      rk_raddr = k_cnt[AW-1:0];
      ST_SUP_BIDX: begin
        st_raddr = rk_rdata;
        sp_raddr = rk_rdata;
      end
      ST_SUP_DEC:    sp_we = pair_hit;
      ST_EMIT_RD:    sp_raddr = i_cnt[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      thresh     <= ThreshReset;
      count      <= '0;
      i_cnt      <= '0;
      k_cnt      <= '0;
      supp_cnt   <= '0;
      kept_total <= '0;
      emit_seen  <= '0;
      out_valid  <= 1'b0;
      kept_index <= '0;
      last_kept  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) thresh <= cfg_wdata;
      unique case (state)
        ST_LOAD: begin
          if (load_take) begin
            if (room) count <= count + CW'(1);
            i_cnt    <= '0;
            k_cnt    <= '0;
            supp_cnt <= '0;
          end
        end
        ST_SORT_RD:    if (i_cnt == count) i_cnt <= '0;
        ST_SORT_CUR:   cur_score <= scr_rdata;
        ST_SORT_SCORE: prev_rank <= rk_rdata;
        ST_SORT_CMP:   if (scr_rdata < cur_score) k_cnt <= k_dec;
        ST_SORT_PUT: begin
          i_cnt <= i_cnt + CW'(1);
          k_cnt <= i_cnt + CW'(1);
        end
        ST_SUP_ACHK: begin
          a_box <= crn_rdata;
          aw_r  <= span16(crn_rdata[15:0], crn_rdata[47:32]);
          ah_r  <= span16(crn_rdata[31:16], crn_rdata[63:48]);
          k_cnt <= i_cnt + CW'(1);
          if (sp_rdata) i_cnt <= i_cnt + CW'(1);
        end
        ST_SUP_AAREA:  area_a_r <= mul_p[31:0];
        ST_SUP_B:      if (k_cnt == count) i_cnt <= i_cnt + CW'(1);
        ST_SUP_BIDX:   b_idx <= rk_rdata;
        ST_SUP_GEOM: begin
          iw_r <= iw;
          ih_r <= ih;
          bw_r <= bw;
          bh_r <= bh;
          if (sp_rdata) k_cnt <= k_cnt + CW'(1);
        end
        ST_SUP_MUL_I:  inter_r  <= mul_p[31:0];
        ST_SUP_MUL_B:  area_b_r <= mul_p[31:0];
        ST_SUP_MUL_T:  rhs_r    <= mul_p;
        ST_SUP_DEC: begin
          if (pair_hit) supp_cnt <= supp_cnt + CW'(1);
          k_cnt <= k_cnt + CW'(1);
        end
        ST_EMIT_INIT: begin
          kept_total <= count - supp_cnt;
          i_cnt      <= '0;
          emit_seen  <= '0;
        end
        ST_EMIT_RD:    if (i_cnt == count) count <= '0;
        ST_EMIT_CHK: begin
          if (sp_rdata) begin
            i_cnt <= i_cnt + CW'(1);
          end else begin
            kept_index <= IndexW'(i_cnt);
            last_kept  <= (emit_seen + CW'(1) == kept_total);
            out_valid  <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            emit_seen <= emit_seen + CW'(1);
            i_cnt     <= i_cnt + CW'(1);
            if (last_kept) count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `BNMS_ASSERT_IMP(a_ready_load, in_ready, state == ST_LOAD)
  `BNMS_ASSERT_IMP(a_cnt_cap, 1'b1, count <= CW'(MAX_BOXES))
  `BNMS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kept_index) && $stable(last_kept))
  `BNMS_ASSERT_NXT(a_last_done, out_valid && out_ready && last_kept, !out_valid)
endmodule
